### rtl/gcl_pkg.sv
package gcl_pkg;

    localparam int OPD_W = 31;
    localparam int GCD_W = 31;
    localparam int LCM_W = 62;

    typedef struct packed {
        logic load;
        logic div_init;
        logic sel_lcm;
        logic div_step;
        logic swap;
        logic zero_lcm;
        logic mul;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic y_zero;
        logic a_zero;
        logic b_zero;
        logic div_last;
    } t_dp_sts;

endpackage

### rtl/gcl_datapath.sv
module gcl_datapath
    import gcl_pkg::*;
#(
    parameter int OPERAND_WIDTH = 31
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic [OPD_W-1:0]    i_operand_a,
    input  logic [OPD_W-1:0]    i_operand_b,
    output t_dp_sts             o_sts,
    output logic                o_valid,
    output logic [GCD_W-1:0]    o_gcd_value,
    output logic [LCM_W-1:0]    o_lcm_value
);

    localparam int W  = OPERAND_WIDTH;
    localparam int CW = $clog2(W);
    localparam int PW = 2 * W;

    logic [W-1:0]  r_a, r_b, r_x, r_y;
    logic [W-1:0]  r_dvd, r_dvs, r_rem;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] r_prod;

    logic [W+OPD_W-1:0] n_a_ext, n_b_ext;
    logic [W:0]         n_rem_sh;
    logic [W:0]         n_rem_sub;
    logic               n_qbit;
    logic [GCD_W+W-1:0] n_gcd_ext;
    logic [LCM_W+PW-1:0] n_lcm_ext;

    assign n_a_ext   = {{W{1'b0}}, i_operand_a};
    assign n_b_ext   = {{W{1'b0}}, i_operand_b};
    assign n_rem_sh  = {r_rem, r_dvd[W-1]};
    assign n_rem_sub = n_rem_sh - {1'b0, r_dvs};
    assign n_qbit    = !n_rem_sub[W];
    assign n_gcd_ext = {{GCD_W{1'b0}}, r_x};
    assign n_lcm_ext = {{LCM_W{1'b0}}, r_prod};

    assign o_sts.y_zero   = (r_y == '0);
    assign o_sts.a_zero   = (r_a == '0);
    assign o_sts.b_zero   = (r_b == '0);
    assign o_sts.div_last = (r_cnt == CW'(W - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a <= n_a_ext[W-1:0];
            r_b <= n_b_ext[W-1:0];
            r_x <= n_a_ext[W-1:0];
            r_y <= n_b_ext[W-1:0];
        end else if (i_cmd.swap) begin
            r_x <= r_y;
            r_y <= r_rem;
        end
        if (i_cmd.div_init) begin
            r_dvd <= i_cmd.sel_lcm ? r_a : r_x;
            r_dvs <= i_cmd.sel_lcm ? r_x : r_y;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[W-2:0], n_qbit};
            r_rem <= n_qbit ? n_rem_sub[W-1:0] : n_rem_sh[W-1:0];
            r_cnt <= r_cnt + CW'(1);
        end
        if (i_cmd.zero_lcm) begin
            r_prod <= '0;
        end else if (i_cmd.mul) begin
            r_prod <= PW'(r_dvd) * PW'(r_b);
        end
        if (i_cmd.emit) begin
            o_gcd_value <= n_gcd_ext[GCD_W-1:0];
            o_lcm_value <= n_lcm_ext[LCM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit;
        end
    end

endmodule

### rtl/gcl_ctrl.sv
module gcl_ctrl
    import gcl_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_SWAP  = 3'd3;
    localparam logic [2:0] S_QDIV  = 3'd4;
    localparam logic [2:0] S_MUL   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] r_state, n_state;

    assign busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_sts.y_zero) begin
                    o_cmd.div_init = 1'b1;
                    n_state        = S_DIV;
                end else if (i_sts.a_zero || i_sts.b_zero) begin
                    o_cmd.zero_lcm = 1'b1;
                    n_state        = S_OUT;
                end else begin
                    // gcd settled in x: divide a by it for the lcm
                    o_cmd.div_init = 1'b1;
                    o_cmd.sel_lcm  = 1'b1;
                    n_state        = S_QDIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_SWAP;
                end
            end
            S_SWAP: begin
                o_cmd.swap = 1'b1;
                n_state    = S_CHECK;
            end
            S_QDIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### rtl/gcd_lcm_unit.sv
// gcd_lcm_unit: greatest common divisor and least common multiple.
// Request: drive i_operand_a/i_operand_b and raise start; the request is
// taken at the clock edge where start is high and busy is low. Only the
// low OPERAND_WIDTH bits of each operand are used.
// Result: o_gcd_value and o_lcm_value are valid for the single cycle in
// which o_valid is high; the receiver must take them then (no stall).
// lcm is 0 when either operand is 0; gcd is then the other operand.
// Operation: one radix-2 restoring divider, one quotient bit a cycle, does
// every Euclid remainder step and the final a/gcd division. Each Euclid
// step runs the check, divide and swap states; the lcm then takes a
// divide of a by the gcd and a multiply by b. o_valid is high in the
// first cycle in which busy is low again. One request is in flight at a
// time; the next one may be taken in the o_valid cycle.
// Reset (synchronous, active low) returns the controller to idle and
// drops o_valid; a request in flight is lost.
module gcd_lcm_unit
    import gcl_pkg::*;
#(
    parameter int OPERAND_WIDTH = 31
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OPD_W-1:0]  i_operand_a,
    input  logic [OPD_W-1:0]  i_operand_b,
    output logic              o_valid,
    output logic [GCD_W-1:0]  o_gcd_value,
    output logic [LCM_W-1:0]  o_lcm_value
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    gcl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    gcl_datapath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_sts       (w_sts),
        .o_valid     (o_valid),
        .o_gcd_value (o_gcd_value),
        .o_lcm_value (o_lcm_value)
    );

endmodule

### dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import gcl_pkg::*;

    localparam int OPERAND_WIDTH = 31;
    localparam int RANDOM_PAIRS  = 1800;
    localparam int CALM_TAIL     = 200;
    localparam int unsigned MAX_OPD = (32'h1 << OPERAND_WIDTH) - 1;

    typedef struct {
        bit [OPD_W-1:0] a;
        bit [OPD_W-1:0] b;
        int unsigned    gap;
        bit             drain;
    } operand_pair_t;

    typedef struct {
        bit [GCD_W-1:0] gcd;
        bit [LCM_W-1:0] lcm;
    } gcd_lcm_t;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             start       = 1'b0;
    logic [OPD_W-1:0] i_operand_a = '0;
    logic [OPD_W-1:0] i_operand_b = '0;
    logic             busy;
    logic             o_valid;
    logic [GCD_W-1:0] o_gcd_value;
    logic [LCM_W-1:0] o_lcm_value;

    operand_pair_t operand_queue[$];
    gcd_lcm_t      expected_pairs[$];
    int unsigned   mismatch_count = 0;
    int unsigned   gap_left       = 0;
    bit            gap_loaded     = 1'b0;

    gcd_lcm_unit #(
        .OPERAND_WIDTH(OPERAND_WIDTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_valid     (o_valid),
        .o_gcd_value (o_gcd_value),
        .o_lcm_value (o_lcm_value)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic gcd_lcm_t gcd_lcm_of(bit [OPD_W-1:0] a_in, bit [OPD_W-1:0] b_in);
        bit [OPD_W-1:0] opd_mask;
        bit [OPD_W-1:0] x;
        bit [OPD_W-1:0] y;
        bit [OPD_W-1:0] r;
        gcd_lcm_t       res;
        opd_mask = OPD_W'(MAX_OPD);
        x = a_in & opd_mask;
        y = b_in & opd_mask;
        while (y != 0) begin
            r = x % y;
            x = y;
            y = r;
        end
        res.gcd = GCD_W'(x);
        res.lcm = '0;
        if ((a_in & opd_mask) != 0 && (b_in & opd_mask) != 0 && x != 0)
            res.lcm = LCM_W'((a_in & opd_mask) / x) * LCM_W'(b_in & opd_mask);
        return res;
    endfunction

    function automatic void add_pair(int unsigned a, int unsigned b, int unsigned gap,
                                     bit drain);
        operand_pair_t p;
        p.a     = OPD_W'(a);
        p.b     = OPD_W'(b);
        p.gap   = gap;
        p.drain = drain;
        operand_queue.push_back(p);
    endfunction

    function automatic int unsigned narrow_value();
        int unsigned w;
        w = $urandom_range(1, OPERAND_WIDTH);
        return $urandom & ((32'h1 << w) - 1);
    endfunction

    // driver: holds a request until taken, then waits out the next one's gap and drain
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start      <= 1'b0;
            gap_loaded = 1'b0;
        end else begin
            if (start && !busy) begin
                expected_pairs.push_back(gcd_lcm_of(i_operand_a, i_operand_b));
                operand_queue.pop_front();
                gap_loaded = 1'b0;
            end
            if (!(start && busy)) begin
                if (operand_queue.size() == 0) begin
                    start <= 1'b0;
                end else begin
                    if (!gap_loaded) begin
                        gap_left   = operand_queue[0].gap;
                        gap_loaded = 1'b1;
                    end
                    if (gap_left != 0 ||
                        (operand_queue[0].drain && expected_pairs.size() != 0)) begin
                        if (gap_left != 0)
                            gap_left--;
                        start       <= 1'b0;
                        i_operand_a <= OPD_W'($urandom);
                        i_operand_b <= OPD_W'($urandom);
                    end else begin
                        start       <= 1'b1;
                        i_operand_a <= operand_queue[0].a;
                        i_operand_b <= operand_queue[0].b;
                    end
                end
            end
        end
    end

    // monitor: results cannot be held off, check every strobe
    always @(posedge i_clk) begin
        gcd_lcm_t want;
        if (i_rst_n && o_valid !== 1'b0) begin
            if (expected_pairs.size() == 0) begin
                $display("%0t: unexpected result gcd=%0d lcm=%0d",
                         $time, o_gcd_value, o_lcm_value);
                mismatch_count++;
            end else begin
                want = expected_pairs.pop_front();
                if (o_gcd_value !== want.gcd) begin
                    $display("%0t: gcd mismatch expected=%0d actual=%0d",
                             $time, want.gcd, o_gcd_value);
                    mismatch_count++;
                end
                if (o_lcm_value !== want.lcm) begin
                    $display("%0t: lcm mismatch expected=%0d actual=%0d",
                             $time, want.lcm, o_lcm_value);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        int unsigned a;
        int unsigned b;
        int unsigned g;
        int unsigned gap;
        int unsigned kind;
        bit          idle_on;

        // directed: zeros, extremes, worst-case Euclid, common factors
        add_pair(0, 0, 0, 1'b0);
        add_pair(0, 12345, 0, 1'b0);
        add_pair(987654, 0, 3, 1'b0);
        add_pair(0, MAX_OPD, 0, 1'b0);
        add_pair(MAX_OPD, 0, 0, 1'b0);
        add_pair(MAX_OPD, MAX_OPD, 0, 1'b0);
        add_pair(MAX_OPD, 1, 5, 1'b0);
        add_pair(1, MAX_OPD, 0, 1'b0);
        add_pair(1, 1, 0, 1'b0);
        add_pair(MAX_OPD, MAX_OPD - 1, 0, 1'b0);
        add_pair(MAX_OPD - 1, MAX_OPD, 0, 1'b0);
        add_pair(1836311903, 1134903170, 0, 1'b0);
        add_pair(1134903170, 1836311903, 2, 1'b0);
        add_pair(32'h4000_0000, 32'h4000_0000, 0, 1'b0);
        add_pair(32'h4000_0000, 3, 0, 1'b0);
        add_pair(32'h5555_5555, 32'h2AAA_AAAA, 0, 1'b0);
        add_pair(12, 18, 0, 1'b0);
        add_pair(6, 4, 0, 1'b1);
        add_pair(2147483629, MAX_OPD, 0, 1'b0);
        add_pair(46341, 46341 * 2, 0, 1'b0);
        add_pair(1, 0, 0, 1'b0);
        add_pair(0, 1, 0, 1'b0);

        for (int i = 0; i < RANDOM_PAIRS; i++) begin
            kind = $urandom_range(0, 9);
            if (kind < 4) begin
                a = $urandom & MAX_OPD;
                b = $urandom & MAX_OPD;
            end else if (kind < 7) begin
                a = narrow_value();
                b = narrow_value();
            end else if (kind < 9) begin
                g = $urandom_range(1, 32'h1_0000);
                a = g * $urandom_range(0, MAX_OPD / g);
                b = g * $urandom_range(0, MAX_OPD / g);
            end else begin
                case ($urandom_range(0, 3))
                    0: begin a = 0;               b = $urandom & MAX_OPD; end
                    1: begin a = $urandom & MAX_OPD; b = 0;            end
                    2: begin a = $urandom & MAX_OPD; b = a;            end
                    default: begin a = 1;         b = $urandom & MAX_OPD; end
                endcase
            end
            idle_on = ((i / 60) % 2 == 0) && (i < RANDOM_PAIRS - CALM_TAIL);
            gap = 0;
            if (idle_on && $urandom_range(0, 3) == 0)
                gap = $urandom_range(1, 8);
            add_pair(a, b, gap, (i % 600 == 0) ||
                     ((i < RANDOM_PAIRS - CALM_TAIL) && $urandom_range(0, 199) == 0));
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (operand_queue.size() != 0 || start || expected_pairs.size() != 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #(60_000_000);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/gcl_pkg.sv
rtl/gcl_datapath.sv
rtl/gcl_ctrl.sv
rtl/gcd_lcm_unit.sv
dv/tb.sv
